[rtl/core/pbst_pkg.sv]
`default_nettype none

package pbst_pkg;

	// key and stream widths
	localparam int KEY_W       = 32;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 2;
	localparam int OP_W        = 1;
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 2;

	// default pool size
	localparam int NODES_DEF = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OP_W-1:0] OP_DELETE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

endpackage

`default_nettype wire

[rtl/core/pbst_node_mem.sv]
`default_nettype none

module pbst_node_mem #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 42
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]                      wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [DATA_W-1:0]                      rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/core/pooled_bst_insert_delete.sv]
// pooled bst, insert and delete; full/empty skip the tree, missing ends the search; insert
// takes the free head, then walks to the leaf's parent unless the tree is empty; delete
// searches, walks the successor path if there is a right subtree, fixes the successor's old
// parent if it is not the right child, then the parent link and free list; one node read per
// cycle; one item in flight, next beat taken the cycle after the result is loaded; a stalled
// result beat holds S_FIN; reset: async, active low; a clearing pass then rebuilds free list
`default_nettype none

module pooled_bst_insert_delete #(
	parameter int NODES = pbst_pkg::NODES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input stream
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [pbst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] key (signed)
	input  wire logic [pbst_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // [0] operation
	// result stream
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic      [pbst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [3:0] node_slot, [7:4] zero
	output logic      [pbst_pkg::OUT_TUSER_W-1:0]   m_axis_tuser   // [1:0] status
);

	import pbst_pkg::*;

	// slot address width, link width (null is the value NODES), node word width
	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = $clog2(NODES + 1);
	localparam int DW = KEY_W + 2 * LW;

	localparam logic [LW-1:0] LINK_NULL = LW'(NODES);
	localparam logic [LW-1:0] STEP_MAX  = LW'(NODES);
	localparam logic [LW-1:0] STEP_LAST = LW'(NODES - 1);

	// sequencer states
	typedef enum logic [10:0] {
		S_CLR       = 11'b000_0000_0001,
		S_IDLE      = 11'b000_0000_0010,
		S_INS_FREE  = 11'b000_0000_0100,
		S_INS_WALK  = 11'b000_0000_1000,
		S_DEL_SRCH  = 11'b000_0001_0000,
		S_DEL_SUCC  = 11'b000_0010_0000,
		S_DEL_SPREV = 11'b000_0100_0000,
		S_DEL_PAR   = 11'b000_1000_0000,
		S_DEL_FREE  = 11'b001_0000_0000,
		S_FIN       = 11'b010_0000_0000,
		S_SPARE     = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// control registers
	logic [LW-1:0]          clr_q;
	logic [LW-1:0]          root_q;
	logic [LW-1:0]          free_q;
	logic [LW-1:0]          cur_q;
	logic [LW-1:0]          parent_q;
	logic [LW-1:0]          succ_q;
	logic [LW-1:0]          sprev_q;
	logic [LW-1:0]          repl_q;
	logic [LW-1:0]          steps_q;
	logic                   dir_q;          // 1: cur hangs on the parent's left
	logic [STATUS_W-1:0]    res_status_q;
	logic                   m_tvalid_q;

	// payload registers
	logic signed [KEY_W-1:0] key_q;
	logic [AW-1:0]           slot_q;
	logic [LW-1:0]           cl_q;           // left link of the node being deleted
	logic [LW-1:0]           cr_q;           // right link of the node being deleted
	logic [LW-1:0]           succr_q;        // right link of the successor
	logic [DW-1:0]           parnode_q;
	logic [DW-1:0]           sprevnode_q;
	logic [STATUS_W-1:0]     m_status_q;
	logic [SLOT_W-1:0]       m_slot_q;

	// node memory port
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [DW-1:0]           wr_data;
	logic [AW-1:0]           rd_addr;
	logic [DW-1:0]           rd_data;

	// node word fields: {key, left, right}
	logic signed [KEY_W-1:0] rd_key;
	logic [LW-1:0]           rd_left;
	logic [LW-1:0]           rd_right;
	logic signed [KEY_W-1:0] par_key;
	logic [LW-1:0]           par_left;
	logic [LW-1:0]           par_right;
	logic signed [KEY_W-1:0] sp_key;
	logic [LW-1:0]           sp_right;

	logic                    key_above;
	logic                    key_hit;
	logic [LW-1:0]           walk_next;
	logic [LW-1:0]           steps_inc;
	logic [LW-1:0]           slot_link;
	logic [LW-1:0]           clr_next;
	logic                    ins_more;
	logic                    srch_stop;
	logic                    succ_more;
	logic                    in_beat;
	logic                    out_free;
	logic [AW+SLOT_W-1:0]    slot_wide;

	function automatic logic is_slot(input logic [LW-1:0] s);
		return s < LINK_NULL;
	endfunction

	assign rd_key    = rd_data[DW-1 -: KEY_W];
	assign rd_left   = rd_data[2*LW-1:LW];
	assign rd_right  = rd_data[LW-1:0];
	assign par_key   = parnode_q[DW-1 -: KEY_W];
	assign par_left  = parnode_q[2*LW-1:LW];
	assign par_right = parnode_q[LW-1:0];
	assign sp_key    = sprevnode_q[DW-1 -: KEY_W];
	assign sp_right  = sprevnode_q[LW-1:0];

	// signed compare against the node just read
	assign key_above = rd_key > key_q;
	assign key_hit   = rd_key == key_q;
	assign walk_next = key_above ? rd_left : rd_right;
	assign steps_inc = steps_q + LW'(1);
	assign slot_link = LW'(slot_q);
	assign clr_next  = clr_q + LW'(1);

	// walk continuation tests
	assign ins_more  = is_slot(walk_next) && (steps_q < STEP_LAST);
	assign srch_stop = (steps_q == STEP_MAX) || !is_slot(walk_next);
	assign succ_more = is_slot(rd_left) && (steps_q < STEP_MAX);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;

	// node_slot carries the low bits of the slot number
	assign slot_wide = {{SLOT_W{1'b0}}, slot_q};

	pbst_node_mem #(
		.DEPTH  (NODES),
		.DATA_W (DW)
	) u_node_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// memory port: one read and at most one write per cycle
	always_comb begin
		rd_addr = cur_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_CLR: begin
				// rebuild the free chain: slot i links to slot i+1, last one to null
				wr_en   = 1'b1;
				wr_addr = clr_q[AW-1:0];
				wr_data = {KEY_W'(0), LINK_NULL, clr_next};
			end
			S_IDLE: begin
				rd_addr = (s_axis_tuser == OP_INSERT) ? free_q[AW-1:0] : root_q[AW-1:0];
			end
			S_INS_FREE: begin
				// new leaf takes the free head
				wr_en   = 1'b1;
				wr_addr = free_q[AW-1:0];
				wr_data = {key_q, LINK_NULL, LINK_NULL};
				rd_addr = root_q[AW-1:0];
			end
			S_INS_WALK: begin
				rd_addr = walk_next[AW-1:0];
				if (!ins_more) begin
					// attach the leaf below the last node on the path
					wr_en   = 1'b1;
					wr_addr = cur_q[AW-1:0];
					wr_data = key_above ? {rd_key, slot_link, rd_right}
					                    : {rd_key, rd_left, slot_link};
				end
			end
			S_DEL_SRCH: begin
				rd_addr = key_hit ? rd_right[AW-1:0] : walk_next[AW-1:0];
			end
			S_DEL_SUCC: begin
				rd_addr = rd_left[AW-1:0];
				if (!succ_more) begin
					// successor takes the deleted node's left link, and its right link unless it is that right child
					wr_en   = 1'b1;
					wr_addr = succ_q[AW-1:0];
					wr_data = is_slot(sprev_q) ? {rd_key, cl_q, cr_q}
					                           : {rd_key, cl_q, rd_right};
				end
			end
			S_DEL_SPREV: begin
				// successor's old parent adopts the successor's right subtree
				wr_en   = 1'b1;
				wr_addr = sprev_q[AW-1:0];
				wr_data = {sp_key, succr_q, sp_right};
			end
			S_DEL_PAR: begin
				if (is_slot(parent_q)) begin
					wr_en   = 1'b1;
					wr_addr = parent_q[AW-1:0];
					wr_data = dir_q ? {par_key, repl_q, par_right}
					                : {par_key, par_left, repl_q};
				end
			end
			S_DEL_FREE: begin
				// freed slot goes to the head of the free list
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = {KEY_W'(0), LINK_NULL, free_q};
			end
			S_FIN, S_SPARE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			root_q       <= LINK_NULL;
			free_q       <= '0;
			cur_q        <= LINK_NULL;
			parent_q     <= LINK_NULL;
			succ_q       <= LINK_NULL;
			sprev_q      <= LINK_NULL;
			repl_q       <= LINK_NULL;
			steps_q      <= '0;
			dir_q        <= 1'b0;
			res_status_q <= ST_DONE;
			m_tvalid_q   <= 1'b0;
		end else begin
			// result register: loaded when the item finishes, cleared once taken
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_next;
					if (clr_q == STEP_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_beat) begin
						if (s_axis_tuser == OP_INSERT) begin
							if (!is_slot(free_q)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_INS_FREE;
							end
						end else begin
							if (!is_slot(root_q)) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								cur_q    <= root_q;
								parent_q <= LINK_NULL;
								steps_q  <= '0;
								state_q  <= S_DEL_SRCH;
							end
						end
					end
				end
				S_INS_FREE: begin
					free_q <= rd_right;
					if (!is_slot(root_q)) begin
						root_q       <= free_q;
						res_status_q <= ST_DONE;
						state_q      <= S_FIN;
					end else begin
						cur_q   <= root_q;
						steps_q <= '0;
						state_q <= S_INS_WALK;
					end
				end
				S_INS_WALK: begin
					if (ins_more) begin
						cur_q   <= walk_next;
						steps_q <= steps_inc;
					end else begin
						res_status_q <= ST_DONE;
						state_q      <= S_FIN;
					end
				end
				S_DEL_SRCH: begin
					if (key_hit) begin
						if (is_slot(rd_right)) begin
							succ_q  <= rd_right;
							sprev_q <= LINK_NULL;
							steps_q <= '0;
							state_q <= S_DEL_SUCC;
						end else begin
							repl_q  <= rd_left;
							state_q <= S_DEL_PAR;
						end
					end else if (srch_stop) begin
						res_status_q <= ST_MISSING;
						state_q      <= S_FIN;
					end else begin
						parent_q <= cur_q;
						dir_q    <= key_above;
						cur_q    <= walk_next;
						steps_q  <= steps_inc;
					end
				end
				S_DEL_SUCC: begin
					if (succ_more) begin
						sprev_q <= succ_q;
						succ_q  <= rd_left;
						steps_q <= steps_inc;
					end else begin
						repl_q  <= succ_q;
						state_q <= is_slot(sprev_q) ? S_DEL_SPREV : S_DEL_PAR;
					end
				end
				S_DEL_SPREV: begin
					state_q <= S_DEL_PAR;
				end
				S_DEL_PAR: begin
					if (!is_slot(parent_q)) begin
						root_q <= repl_q;
					end
					state_q <= S_DEL_FREE;
				end
				S_DEL_FREE: begin
					free_q       <= LW'(slot_q);
					res_status_q <= ST_DONE;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					// hold the result until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SPARE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (in_beat) begin
			key_q <= signed'(s_axis_tdata[KEY_W-1:0]);
		end
		if (state_q == S_INS_FREE) begin
			slot_q <= free_q[AW-1:0];
		end
		if (state_q == S_DEL_SRCH) begin
			if (key_hit) begin
				slot_q <= cur_q[AW-1:0];
				cl_q   <= rd_left;
				cr_q   <= rd_right;
			end else begin
				parnode_q <= rd_data;
			end
		end
		if (state_q == S_DEL_SUCC) begin
			if (succ_more) begin
				sprevnode_q <= rd_data;
			end else begin
				succr_q <= rd_right;
			end
		end
		if (state_q == S_FIN && out_free) begin
			m_status_q <= res_status_q;
			m_slot_q   <= (res_status_q == ST_DONE) ? slot_wide[SLOT_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - SLOT_W)'(0), m_slot_q};

`ifndef NO_ASSERTIONS
	// the node memory is never written while no item is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> !wr_en)
		else $error("node memory written outside an operation");

	// a failed operation reports slot zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == '0))
		else $error("nonzero slot on a failed operation");

	// an insert into a full pool goes straight to the result
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_axis_tuser == OP_INSERT && !is_slot(free_q)) |=> (state_q == S_FIN))
		else $error("full pool insert did not finish at once");

	// free head is a slot or the null value
	assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= LINK_NULL)
		else $error("free head out of range");
`endif

endmodule

`default_nettype wire
